@@ rtl/circumcircle_three_points_assert.svh @@
// Assertion macros used by the circumcircle top module.
// Each macro expects clk and rst to be visible where it is used.
`ifndef CIRCUMCIRCLE_THREE_POINTS_ASSERT_SVH
`define CIRCUMCIRCLE_THREE_POINTS_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define CTP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circumcircle assertion failed");

// Next-cycle implication, ignored while reset is high.
`define CTP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circumcircle assertion failed");

// A signal that reset must clear by the following edge.
`define CTP_ASSERT_RESET(name, sig) \
  name: assert property (@(posedge clk) rst |=> !(sig)) \
    else $error("circumcircle reset assertion failed");

`endif

@@ rtl/ctp_pkg.sv @@
// Types, widths and helper functions for the circumcircle pipeline.
// No dependencies; every RTL module imports this package.
package ctp_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DIST_W     = SQ_W + 1;
  localparam int S_W        = 2 * COORD_BITS + 2;
  localparam int DET_W      = 2 * COORD_BITS + 3;
  localparam int T_W        = DIFF_W + S_W;
  localparam int NUM_W      = T_W + 1;
  localparam int DEN_W      = DET_W;
  localparam int CENTER_W   = 40;
  localparam int RADIUS_W   = 63;

  localparam logic [CENTER_W-1:0] CENTER_MAX = {1'b0, {(CENTER_W-1){1'b1}}};
  localparam logic [CENTER_W-1:0] CENTER_MIN = {1'b1, {(CENTER_W-1){1'b0}}};
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_CIRCLE    = 2'd0,
    KIND_COINCIDE  = 2'd1,
    KIND_COLLINEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] third_x;
    logic signed [COORD_BITS-1:0] third_y;
  } in_t;

  typedef struct packed {
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic [RADIUS_W-1:0]        radius_squared;
    kind_t                      case_kind;
    logic                       overflow;
  } out_t;

  typedef struct packed {
    logic                         neg_x;
    logic                         neg_y;
    kind_t                        kind;
    logic [CENTER_W-1:0]          pair_cx;
    logic [CENTER_W-1:0]          pair_cy;
    logic [RADIUS_W-1:0]          pair_r;
    logic                         pair_ovf;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
  } side_t;

  // Returns {overflow, value} for a sign and magnitude center coordinate.
  function automatic logic [CENTER_W:0] sat_center(input logic neg, input logic [63:0] mag);
    logic [CENTER_W:0] res;
    if (neg) begin
      if (mag > 64'(CENTER_MIN)) res = {1'b1, CENTER_MIN};
      else res = {1'b0, CENTER_W'(64'd0 - mag)};
    end else if (mag > 64'(CENTER_MAX)) begin
      res = {1'b1, CENTER_MAX};
    end else begin
      res = {1'b0, mag[CENTER_W-1:0]};
    end
    return res;
  endfunction

  // Returns {overflow, value} for an unsigned squared radius.
  function automatic logic [RADIUS_W:0] sat_radius(input logic [63:0] v);
    logic [RADIUS_W:0] res;
    if (v[63]) res = {1'b1, RADIUS_MAX};
    else res = {1'b0, v[RADIUS_W-1:0]};
    return res;
  endfunction

endpackage

@@ rtl/circumcircle_three_points.sv @@
// Disc through three integer points: each item carries three signed 16-bit points and
// yields the center (CENTER_FRAC_BITS fraction bits, saturated to 40 bits), the squared
// radius (twice as many fraction bits, saturated to 63 bits), the case and an overflow
// flag. One item is taken every clock cycle while the output side keeps up. It has five
// front stages, one divider stage per quotient bit of the 52-bit center numerator plus
// its fraction bits, and five back stages. A stall at the output holds the whole
// pipeline in place.
`include "circumcircle_three_points_assert.svh"

module circumcircle_three_points import ctp_pkg::*; #(
  parameter int CENTER_FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic point_valid,
  output logic point_ready,
  input  in_t  points,
  output logic disc_valid,
  input  logic disc_ready,
  output out_t disc
);

  localparam int QUO_W = NUM_W + CENTER_FRAC_BITS;

  logic             en;
  logic             front_valid;
  logic [NUM_W-1:0] mag_x, mag_y;
  logic [DEN_W-1:0] den;
  side_t            front_side;
  logic             div_valid;
  logic [QUO_W-1:0] quo_x, quo_y;
  side_t            div_side;

  assign en          = !disc_valid || disc_ready;
  assign point_ready = en;

  ctp_front #(.CENTER_FRAC_BITS(CENTER_FRAC_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .valid       (point_valid),
    .points      (points),
    .front_valid (front_valid),
    .mag_x       (mag_x),
    .mag_y       (mag_y),
    .den         (den),
    .side        (front_side)
  );

  ctp_div #(.CENTER_FRAC_BITS(CENTER_FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .den       (den),
    .side_in   (front_side),
    .out_valid (div_valid),
    .quo_x     (quo_x),
    .quo_y     (quo_y),
    .side_out  (div_side)
  );

  ctp_back #(.CENTER_FRAC_BITS(CENTER_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .quo_x     (quo_x),
    .quo_y     (quo_y),
    .side_in   (div_side),
    .out_valid (disc_valid),
    .disc      (disc)
  );

  `CTP_ASSERT_RESET(a_reset_clears_output, disc_valid)
  `CTP_ASSERT_NEXT(a_stall_freezes_pipe, disc_valid && !disc_ready, $stable(div_valid) && $stable(front_valid))
  `CTP_ASSERT_IMPL(a_full_radius_flags, disc_valid && (&disc.radius_squared), disc.overflow)

endmodule

@@ rtl/ctp_front.sv @@
// Front pipeline: determinant, center numerators, divisor and the degenerate disc.
// Depends on ctp_pkg; five register stages.
module ctp_front import ctp_pkg::*; #(
  parameter int CENTER_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid,
  input  in_t               points,
  output logic              front_valid,
  output logic [NUM_W-1:0]  mag_x,
  output logic [NUM_W-1:0]  mag_y,
  output logic [DEN_W-1:0]  den,
  output side_t             side
);

  logic [4:0] vld;

  logic signed [COORD_BITS-1:0] s1_x1, s1_y1, s1_x2, s1_y2, s1_x3, s1_y3;
  logic signed [DIFF_W-1:0]     s1_da, s1_db, s1_dc, s1_de, s1_df, s1_dg;

  logic signed [COORD_BITS-1:0] s2_x1, s2_y1, s2_x2, s2_y2, s2_x3, s2_y3;
  logic signed [DIFF_W-1:0]     s2_da, s2_db, s2_dc, s2_de;
  logic signed [PROD_W-1:0]     s2_pab, s2_pce;
  logic [SQ_W-1:0]              s2_qx1, s2_qy1, s2_qx2, s2_qy2, s2_qx3, s2_qy3;
  logic [SQ_W-1:0]              s2_qa, s2_qb, s2_qc, s2_qe, s2_qf, s2_qg;

  logic signed [COORD_BITS-1:0] s3_x1, s3_y1, s3_x2, s3_y2, s3_x3, s3_y3;
  logic signed [DIFF_W-1:0]     s3_da, s3_db, s3_dc, s3_de;
  logic signed [DET_W-1:0]      s3_det;
  logic signed [S_W-1:0]        s3_s1, s3_s2;
  logic [DIST_W-1:0]            s3_d12, s3_d13, s3_d23;

  logic signed [COORD_BITS-1:0] s4_x1, s4_y1;
  logic signed [DET_W-1:0]      s4_det;
  logic signed [T_W-1:0]        s4_t1, s4_t2, s4_t3, s4_t4;
  logic signed [DIFF_W-1:0]     s4_psx, s4_psy;
  logic [DIST_W-1:0]            s4_pd;
  kind_t                        s4_kind;

  logic                         coin;
  logic signed [DIFF_W-1:0]     psx, psy;
  logic [DIST_W-1:0]            pd;
  kind_t                        kind_next;

  logic signed [NUM_W-1:0]      nx, ny;
  logic signed [DET_W-1:0]      abs_det;
  logic [DIFF_W-1:0]            pmx, pmy;
  logic [CENTER_W:0]            pcx, pcy;
  logic [RADIUS_W:0]            pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], valid};
    end
  end

  assign front_valid = vld[4];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x1 <= points.first_x;
      s1_y1 <= points.first_y;
      s1_x2 <= points.second_x;
      s1_y2 <= points.second_y;
      s1_x3 <= points.third_x;
      s1_y3 <= points.third_y;
      s1_da <= DIFF_W'(points.first_x) - DIFF_W'(points.second_x);
      s1_db <= DIFF_W'(points.first_y) - DIFF_W'(points.third_y);
      s1_dc <= DIFF_W'(points.first_x) - DIFF_W'(points.third_x);
      s1_de <= DIFF_W'(points.first_y) - DIFF_W'(points.second_y);
      s1_df <= DIFF_W'(points.second_x) - DIFF_W'(points.third_x);
      s1_dg <= DIFF_W'(points.second_y) - DIFF_W'(points.third_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x1  <= s1_x1;
      s2_y1  <= s1_y1;
      s2_x2  <= s1_x2;
      s2_y2  <= s1_y2;
      s2_x3  <= s1_x3;
      s2_y3  <= s1_y3;
      s2_da  <= s1_da;
      s2_db  <= s1_db;
      s2_dc  <= s1_dc;
      s2_de  <= s1_de;
      s2_pab <= s1_da * s1_db;
      s2_pce <= s1_dc * s1_de;
      s2_qx1 <= SQ_W'(s1_x1 * s1_x1);
      s2_qy1 <= SQ_W'(s1_y1 * s1_y1);
      s2_qx2 <= SQ_W'(s1_x2 * s1_x2);
      s2_qy2 <= SQ_W'(s1_y2 * s1_y2);
      s2_qx3 <= SQ_W'(s1_x3 * s1_x3);
      s2_qy3 <= SQ_W'(s1_y3 * s1_y3);
      s2_qa  <= SQ_W'(s1_da * s1_da);
      s2_qb  <= SQ_W'(s1_db * s1_db);
      s2_qc  <= SQ_W'(s1_dc * s1_dc);
      s2_qe  <= SQ_W'(s1_de * s1_de);
      s2_qf  <= SQ_W'(s1_df * s1_df);
      s2_qg  <= SQ_W'(s1_dg * s1_dg);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x1  <= s2_x1;
      s3_y1  <= s2_y1;
      s3_x2  <= s2_x2;
      s3_y2  <= s2_y2;
      s3_x3  <= s2_x3;
      s3_y3  <= s2_y3;
      s3_da  <= s2_da;
      s3_db  <= s2_db;
      s3_dc  <= s2_dc;
      s3_de  <= s2_de;
      s3_det <= DET_W'(s2_pab) - DET_W'(s2_pce);
      s3_s1  <= S_W'(s2_qx1) + S_W'(s2_qy1) - S_W'(s2_qx2) - S_W'(s2_qy2);
      s3_s2  <= S_W'(s2_qx1) + S_W'(s2_qy1) - S_W'(s2_qx3) - S_W'(s2_qy3);
      s3_d12 <= DIST_W'(s2_qa) + DIST_W'(s2_qe);
      s3_d13 <= DIST_W'(s2_qc) + DIST_W'(s2_qb);
      s3_d23 <= DIST_W'(s2_qf) + DIST_W'(s2_qg);
    end
  end

  always_comb begin
    coin = (s3_d12 == '0) || (s3_d13 == '0) || (s3_d23 == '0);
    if ((coin && (s3_d12 != '0)) ||
        (!coin && (s3_d12 > s3_d23) && (s3_d12 > s3_d13))) begin
      psx = DIFF_W'(s3_x1) + DIFF_W'(s3_x2);
      psy = DIFF_W'(s3_y1) + DIFF_W'(s3_y2);
      pd  = s3_d12;
    end else if (coin || ((s3_d13 > s3_d12) && (s3_d13 > s3_d23))) begin
      psx = DIFF_W'(s3_x1) + DIFF_W'(s3_x3);
      psy = DIFF_W'(s3_y1) + DIFF_W'(s3_y3);
      pd  = s3_d13;
    end else begin
      psx = DIFF_W'(s3_x2) + DIFF_W'(s3_x3);
      psy = DIFF_W'(s3_y2) + DIFF_W'(s3_y3);
      pd  = s3_d23;
    end
    if (s3_det != '0) kind_next = KIND_CIRCLE;
    else if (coin) kind_next = KIND_COINCIDE;
    else kind_next = KIND_COLLINEAR;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x1   <= s3_x1;
      s4_y1   <= s3_y1;
      s4_det  <= s3_det;
      s4_t1   <= s3_db * s3_s1;
      s4_t2   <= s3_de * s3_s2;
      s4_t3   <= s3_dc * s3_s1;
      s4_t4   <= s3_da * s3_s2;
      s4_psx  <= psx;
      s4_psy  <= psy;
      s4_pd   <= pd;
      s4_kind <= kind_next;
    end
  end

  always_comb begin
    nx      = NUM_W'(s4_t1) - NUM_W'(s4_t2);
    ny      = NUM_W'(s4_t4) - NUM_W'(s4_t3);
    abs_det = s4_det[DET_W-1] ? -s4_det : s4_det;
    pmx     = s4_psx[DIFF_W-1] ? DIFF_W'(-s4_psx) : DIFF_W'(s4_psx);
    pmy     = s4_psy[DIFF_W-1] ? DIFF_W'(-s4_psy) : DIFF_W'(s4_psy);
    pcx     = sat_center(s4_psx[DIFF_W-1], 64'(pmx) << (CENTER_FRAC_BITS - 1));
    pcy     = sat_center(s4_psy[DIFF_W-1], 64'(pmy) << (CENTER_FRAC_BITS - 1));
    pr      = sat_radius(64'(s4_pd) << (2 * CENTER_FRAC_BITS - 2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_x         <= nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
      mag_y         <= ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
      den           <= {abs_det[DEN_W-2:0], 1'b0};
      side.neg_x    <= nx[NUM_W-1] ^ s4_det[DET_W-1];
      side.neg_y    <= ny[NUM_W-1] ^ s4_det[DET_W-1];
      side.kind     <= s4_kind;
      side.pair_cx  <= pcx[CENTER_W-1:0];
      side.pair_cy  <= pcy[CENTER_W-1:0];
      side.pair_r   <= pr[RADIUS_W-1:0];
      side.pair_ovf <= pcx[CENTER_W] | pcy[CENTER_W] | pr[RADIUS_W];
      side.x1       <= s4_x1;
      side.y1       <= s4_y1;
    end
  end

endmodule

@@ rtl/ctp_div.sv @@
// Pipelined restoring divider for both center coordinates, one quotient bit per stage.
// Depends on ctp_pkg; the side record travels alongside each item.
module ctp_div import ctp_pkg::*; #(
  parameter int  CENTER_FRAC_BITS = 8,
  localparam int QUO_W = NUM_W + CENTER_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] mag_x,
  input  logic [NUM_W-1:0] mag_y,
  input  logic [DEN_W-1:0] den,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo_x,
  output logic [QUO_W-1:0] quo_y,
  output side_t            side_out
);

  logic [QUO_W-1:0] vld;

  logic [QUO_W-1:0] nqx_r [1:QUO_W];
  logic [QUO_W-1:0] nqy_r [1:QUO_W];
  logic [DEN_W-1:0] remx_r [1:QUO_W];
  logic [DEN_W-1:0] remy_r [1:QUO_W];
  logic [DEN_W-1:0] dn_r [1:QUO_W];
  side_t            sd_r [1:QUO_W];

  logic [QUO_W-1:0] nqx_c [0:QUO_W-1];
  logic [QUO_W-1:0] nqy_c [0:QUO_W-1];
  logic [DEN_W-1:0] remx_c [0:QUO_W-1];
  logic [DEN_W-1:0] remy_c [0:QUO_W-1];
  logic [DEN_W-1:0] dn_c [0:QUO_W-1];
  side_t            sd_c [0:QUO_W-1];
  logic [DEN_W:0]   trial_x [0:QUO_W-1];
  logic [DEN_W:0]   trial_y [0:QUO_W-1];
  logic [DEN_W:0]   diff_x [0:QUO_W-1];
  logic [DEN_W:0]   diff_y [0:QUO_W-1];
  logic [QUO_W-1:0] ge_x, ge_y;

  always_comb begin
    nqx_c[0]  = {mag_x, {CENTER_FRAC_BITS{1'b0}}};
    nqy_c[0]  = {mag_y, {CENTER_FRAC_BITS{1'b0}}};
    remx_c[0] = '0;
    remy_c[0] = '0;
    dn_c[0]   = den;
    sd_c[0]   = side_in;
    for (int k = 1; k < QUO_W; k++) begin
      nqx_c[k]  = nqx_r[k];
      nqy_c[k]  = nqy_r[k];
      remx_c[k] = remx_r[k];
      remy_c[k] = remy_r[k];
      dn_c[k]   = dn_r[k];
      sd_c[k]   = sd_r[k];
    end
    for (int k = 0; k < QUO_W; k++) begin
      trial_x[k] = {remx_c[k], nqx_c[k][QUO_W-1]};
      trial_y[k] = {remy_c[k], nqy_c[k][QUO_W-1]};
      diff_x[k]  = trial_x[k] - {1'b0, dn_c[k]};
      diff_y[k]  = trial_y[k] - {1'b0, dn_c[k]};
      ge_x[k]    = trial_x[k] >= {1'b0, dn_c[k]};
      ge_y[k]    = trial_y[k] >= {1'b0, dn_c[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        nqx_r[k+1]  <= {nqx_c[k][QUO_W-2:0], ge_x[k]};
        nqy_r[k+1]  <= {nqy_c[k][QUO_W-2:0], ge_y[k]};
        remx_r[k+1] <= ge_x[k] ? diff_x[k][DEN_W-1:0] : trial_x[k][DEN_W-1:0];
        remy_r[k+1] <= ge_y[k] ? diff_y[k][DEN_W-1:0] : trial_y[k][DEN_W-1:0];
        dn_r[k+1]   <= dn_c[k];
        sd_r[k+1]   <= sd_c[k];
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo_x     = nqx_r[QUO_W];
  assign quo_y     = nqy_r[QUO_W];
  assign side_out  = sd_r[QUO_W];

endmodule

@@ rtl/ctp_back.sv @@
// Back pipeline: center saturation, squared radius, and the final result register, which
// takes the pair disc for degenerate cases. Depends on ctp_pkg; five register stages.
module ctp_back import ctp_pkg::*; #(
  parameter int  CENTER_FRAC_BITS = 8,
  localparam int QUO_W = NUM_W + CENTER_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [QUO_W-1:0] quo_x,
  input  logic [QUO_W-1:0] quo_y,
  input  side_t            side_in,
  output logic             out_valid,
  output out_t             disc
);

  localparam int DX_W    = CENTER_W + 1;
  localparam int HALF_W  = DX_W / 2;
  localparam int HI_W    = DX_W - HALF_W;
  localparam int AXIS_W  = 2 * DX_W;
  localparam int TOTAL_W = AXIS_W + 1;

  logic [4:0] vld;

  logic [63:0]       sat_mx, sat_my;
  logic [CENTER_W:0] sat_x, sat_y;

  logic signed [CENTER_W-1:0] b1_cx, b1_cy, b2_cx, b2_cy, b3_cx, b3_cy, b4_cx, b4_cy;
  logic                       b1_ovf, b2_ovf, b3_ovf, b4_ovf;
  side_t                      b1_side, b2_side, b3_side, b4_side;

  logic signed [DX_W-1:0] dx, dy;
  logic [DX_W-1:0]        b2_mx, b2_my;

  logic [2*HI_W-1:0]        b3_hhx, b3_hhy;
  logic [HI_W+HALF_W-1:0]   b3_hlx, b3_hly;
  logic [2*HALF_W-1:0]      b3_llx, b3_lly;

  logic [AXIS_W-1:0]  b4_sqx, b4_sqy;
  logic [TOTAL_W-1:0] total;
  logic               ovf_r;
  logic [RADIUS_W-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  assign out_valid = vld[4];

  always_comb begin
    sat_mx = (|quo_x[QUO_W-1:CENTER_W]) ? {64{1'b1}} : 64'(quo_x[CENTER_W-1:0]);
    sat_my = (|quo_y[QUO_W-1:CENTER_W]) ? {64{1'b1}} : 64'(quo_y[CENTER_W-1:0]);
    sat_x  = sat_center(side_in.neg_x, sat_mx);
    sat_y  = sat_center(side_in.neg_y, sat_my);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_cx   <= sat_x[CENTER_W-1:0];
      b1_cy   <= sat_y[CENTER_W-1:0];
      b1_ovf  <= sat_x[CENTER_W] | sat_y[CENTER_W];
      b1_side <= side_in;
    end
  end

  always_comb begin
    dx = DX_W'(b1_cx) - (DX_W'(b1_side.x1) <<< CENTER_FRAC_BITS);
    dy = DX_W'(b1_cy) - (DX_W'(b1_side.y1) <<< CENTER_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_mx   <= dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
      b2_my   <= dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);
      b2_cx   <= b1_cx;
      b2_cy   <= b1_cy;
      b2_ovf  <= b1_ovf;
      b2_side <= b1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_hhx  <= b2_mx[DX_W-1:HALF_W] * b2_mx[DX_W-1:HALF_W];
      b3_hlx  <= b2_mx[DX_W-1:HALF_W] * b2_mx[HALF_W-1:0];
      b3_llx  <= b2_mx[HALF_W-1:0] * b2_mx[HALF_W-1:0];
      b3_hhy  <= b2_my[DX_W-1:HALF_W] * b2_my[DX_W-1:HALF_W];
      b3_hly  <= b2_my[DX_W-1:HALF_W] * b2_my[HALF_W-1:0];
      b3_lly  <= b2_my[HALF_W-1:0] * b2_my[HALF_W-1:0];
      b3_cx   <= b2_cx;
      b3_cy   <= b2_cy;
      b3_ovf  <= b2_ovf;
      b3_side <= b2_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b4_sqx  <= (AXIS_W'(b3_hhx) << (2 * HALF_W)) + (AXIS_W'(b3_hlx) << (HALF_W + 1))
                 + AXIS_W'(b3_llx);
      b4_sqy  <= (AXIS_W'(b3_hhy) << (2 * HALF_W)) + (AXIS_W'(b3_hly) << (HALF_W + 1))
                 + AXIS_W'(b3_lly);
      b4_cx   <= b3_cx;
      b4_cy   <= b3_cy;
      b4_ovf  <= b3_ovf;
      b4_side <= b3_side;
    end
  end

  always_comb begin
    total  = TOTAL_W'(b4_sqx) + TOTAL_W'(b4_sqy);
    ovf_r  = |total[TOTAL_W-1:RADIUS_W];
    radius = ovf_r ? RADIUS_MAX : total[RADIUS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc.case_kind <= b4_side.kind;
      if (b4_side.kind == KIND_CIRCLE) begin
        disc.center_x       <= b4_cx;
        disc.center_y       <= b4_cy;
        disc.radius_squared <= radius;
        disc.overflow       <= b4_ovf | ovf_r;
      end else begin
        disc.center_x       <= b4_side.pair_cx;
        disc.center_y       <= b4_side.pair_cy;
        disc.radius_squared <= b4_side.pair_r;
        disc.overflow       <= b4_side.pair_ovf;
      end
    end
  end

endmodule

@@ tb/sv/circumcircle_three_points_test.sv @@
// Testbench for the three-point disc pipeline: drives point triples, predicts each disc
// with exact wide integer arithmetic and compares every result field. Depends on ctp_pkg.
`timescale 1ns / 100ps

module circumcircle_three_points_test import ctp_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_ready;
  in_t points = '0;
  logic disc_valid;
  logic disc_ready = 1'b0;
  out_t disc;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  longint cycles = 0;
  out_t expected_discs[$];

  localparam int FRAC = 8;
  localparam longint LIMIT = 400000;

  circumcircle_three_points dut (
    .clk(clk), .rst(rst), .point_valid(point_valid), .point_ready(point_ready),
    .points(points), .disc_valid(disc_valid), .disc_ready(disc_ready), .disc(disc)
  );

  always #1 clk = ~clk;

  function automatic logic [40:0] clamp_center(input logic neg, input logic [127:0] mag);
    if (neg) begin
      if (mag > 128'(64'd1 << 39)) return {1'b1, CENTER_MIN};
      return {1'b0, 40'(128'd0 - mag)};
    end
    if (mag > 128'((64'd1 << 39) - 1)) return {1'b1, CENTER_MAX};
    return {1'b0, mag[39:0]};
  endfunction

  function automatic logic [63:0] clamp_radius(input logic [127:0] v);
    if (v > 128'(RADIUS_MAX)) return {1'b1, RADIUS_MAX};
    return {1'b0, v[62:0]};
  endfunction

  function automatic out_t disc_on_pair(input longint ax, input longint ay,
                                        input longint bx, input longint by);
    out_t r;
    logic [40:0] cx, cy;
    logic [63:0] rr;
    longint sx, sy, d;
    sx = ax + bx;
    sy = ay + by;
    d = (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    cx = clamp_center(sx < 0, 128'(sx < 0 ? -sx : sx) << (FRAC - 1));
    cy = clamp_center(sy < 0, 128'(sy < 0 ? -sy : sy) << (FRAC - 1));
    rr = clamp_radius(128'(d) << (2 * FRAC - 2));
    r.center_x = cx[39:0];
    r.center_y = cy[39:0];
    r.radius_squared = rr[62:0];
    r.overflow = cx[40] | cy[40] | rr[63];
    return r;
  endfunction

  function automatic out_t predict_disc(input in_t p);
    out_t r;
    longint x1, y1, x2, y2, x3, y3, det, d12, d13, d23, s1, s2, dx, dy;
    logic signed [127:0] nx, ny;
    logic [127:0] mx, my, den;
    logic [40:0] cx, cy;
    logic [63:0] rr;
    logic signed [39:0] ccx, ccy;
    x1 = p.first_x; y1 = p.first_y; x2 = p.second_x;
    y2 = p.second_y; x3 = p.third_x; y3 = p.third_y;
    det = (x1 - x2) * (y1 - y3) - (x1 - x3) * (y1 - y2);
    if (det == 0) begin
      d12 = (x1 - x2) * (x1 - x2) + (y1 - y2) * (y1 - y2);
      d13 = (x1 - x3) * (x1 - x3) + (y1 - y3) * (y1 - y3);
      d23 = (x2 - x3) * (x2 - x3) + (y2 - y3) * (y2 - y3);
      if (d12 == 0 || d13 == 0 || d23 == 0) begin
        r = (d12 == 0) ? disc_on_pair(x1, y1, x3, y3) : disc_on_pair(x1, y1, x2, y2);
        r.case_kind = KIND_COINCIDE;
      end else begin
        if (d12 > d23 && d12 > d13) r = disc_on_pair(x1, y1, x2, y2);
        else if (d13 > d12 && d13 > d23) r = disc_on_pair(x1, y1, x3, y3);
        else r = disc_on_pair(x2, y2, x3, y3);
        r.case_kind = KIND_COLLINEAR;
      end
      return r;
    end
    s1 = x1 * x1 + y1 * y1 - x2 * x2 - y2 * y2;
    s2 = x1 * x1 + y1 * y1 - x3 * x3 - y3 * y3;
    nx = 128'(signed'(y1 - y3)) * 128'(signed'(s1)) + 128'(signed'(y2 - y1)) * 128'(signed'(s2));
    ny = 128'(signed'(x3 - x1)) * 128'(signed'(s1)) + 128'(signed'(x1 - x2)) * 128'(signed'(s2));
    den = 128'(2 * (det < 0 ? -det : det));
    mx = nx < 0 ? -nx : nx;
    my = ny < 0 ? -ny : ny;
    mx = (mx << FRAC) / den;
    my = (my << FRAC) / den;
    cx = clamp_center((nx < 0) != (det < 0), mx);
    cy = clamp_center((ny < 0) != (det < 0), my);
    ccx = cx[39:0];
    ccy = cy[39:0];
    dx = longint'(ccx) - x1 * (64'sd1 << FRAC);
    dy = longint'(ccy) - y1 * (64'sd1 << FRAC);
    rr = clamp_radius(128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
                      + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy));
    r.center_x = cx[39:0];
    r.center_y = cy[39:0];
    r.radius_squared = rr[62:0];
    r.case_kind = KIND_CIRCLE;
    r.overflow = cx[40] | cy[40] | rr[63];
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so that the next call can follow without a gap.
  task automatic send_points(input in_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      point_valid <= 1'b0;
      @(negedge clk);
    end
    points <= p;
    point_valid <= 1'b1;
    expected_discs.push_back(predict_disc(p));
    do @(posedge clk); while (!point_ready);
    sent++;
    @(negedge clk);
  endtask

  function automatic in_t pts(input int a, b, c, d, e, f);
    in_t p;
    p.first_x = 16'(a); p.first_y = 16'(b); p.second_x = 16'(c);
    p.second_y = 16'(d); p.third_x = 16'(e); p.third_y = 16'(f);
    return p;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(16) - 8);
      2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                  : 16'h8000 + 16'($urandom_range(3));
      default: return 16'($urandom_range(2000) - 1000);
    endcase
  endfunction

  function automatic in_t rand_points();
    in_t p;
    int k, dx, dy;
    p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(9))
      0: begin p.second_x = p.first_x; p.second_y = p.first_y; end
      1: begin p.third_x = p.second_x; p.third_y = p.second_y; end
      2: begin p.third_x = p.first_x; p.third_y = p.first_y; end
      3, 4: begin
        dx = $urandom_range(200) - 100; dy = $urandom_range(200) - 100;
        k = $urandom_range(6) - 3;
        p.first_x = 16'($urandom_range(2000) - 1000);
        p.first_y = 16'($urandom_range(2000) - 1000);
        p.second_x = p.first_x + 16'(dx); p.second_y = p.first_y + 16'(dy);
        p.third_x = p.first_x + 16'(k * dx); p.third_y = p.first_y + 16'(k * dy);
      end
      5: begin
        p.second_x = p.first_x + 16'd1; p.second_y = p.first_y + 16'd1;
        p.third_x = p.first_x + 16'd2; p.third_y = p.first_y + 16'd3;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic drain();
    point_valid <= 1'b0;
    while (expected_discs.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_points(pts(0, 0, 0, 0, 0, 0));
    send_points(pts(0, 0, 4, 0, 0, 3));
    send_points(pts(1, 1, 1, 1, 5, 7));
    send_points(pts(1, 1, 5, 7, 1, 1));
    send_points(pts(2, 3, 5, 7, 5, 7));
    send_points(pts(0, 0, 2, 2, 5, 5));
    send_points(pts(0, 0, 5, 5, 2, 2));
    send_points(pts(2, 2, 0, 0, 5, 5));
    send_points(pts(0, 0, 1, 0, 2, 0));
    send_points(pts(-1, 0, 1, 0, 0, 0));
    send_points(pts(32767, 32767, -32768, -32768, 32767, -32768));
    send_points(pts(-32768, -32768, -32768, -32768, 32767, 32767));
    send_points(pts(-32768, 32767, 32767, -32768, -32768, -32768));
    send_points(pts(-32768, -32768, 32767, 32766, 32767, 32767));
    send_points(pts(-32768, -32768, 32767, 32767, 32766, 32767));
    send_points(pts(0, 0, 1, 1, 2, 3));
    send_points(pts(-5, 7, 3, -2, 11, 4));
    send_points(pts(32767, 32767, 32767, 32767, 32767, 32767));
    send_points(pts(-32768, 0, 32767, 0, 0, 1));
    send_points(pts(21845, -21846, -1, 0, 1, -1));
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_points(rand_points());
  endtask

  always @(negedge clk)
    if (!rst) disc_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && disc_valid && disc_ready) begin
      if (expected_discs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected disc %h", disc);
      end else begin
        out_t want;
        want = expected_discs.pop_front();
        checked++;
        if (disc.center_x !== want.center_x || disc.center_y !== want.center_y ||
            disc.radius_squared !== want.radius_squared ||
            disc.case_kind !== want.case_kind || disc.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected cx %0d cy %0d r %0d kind %0d ovf %0b,",
                      " got cx %0d cy %0d r %0d kind %0d ovf %0b"},
                     want.center_x, want.center_y, want.radius_squared, want.case_kind,
                     want.overflow, disc.center_x, disc.center_y, disc.radius_squared,
                     disc.case_kind, disc.overflow);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    disc_ready <= 1'b1;
    test_directed();
    drain();
    test_random(300, 0, 0);
    test_random(280, 53, 0);
    drain();
    test_random(280, 0, 53);
    test_random(280, 19, 19);
    drain();
    repeat (100) @(negedge clk);
    $display("Sent %0d point triples and checked %0d discs,", sent, checked);
    $display("covering circles, coincident and collinear triples under back pressure.");
    if (mismatches == 0 && expected_discs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ctp_pkg.sv
rtl/ctp_front.sv
rtl/ctp_div.sv
rtl/ctp_back.sv
rtl/circumcircle_three_points.sv
tb/sv/circumcircle_three_points_test.sv
